### design/egs_pkg.sv
// Shared types and constants for the euclidean gate sequencer.
`default_nettype none

package egs_pkg;

    localparam int CNT_W     = 6;   // step and hit count width
    localparam int ACC_W     = 7;   // accumulator / remainder width
    localparam int POS_OUT_W = 5;   // position field width on the result

    localparam logic [CNT_W-1:0] RESET_STEPS   = 6'd16;
    localparam logic [CNT_W-1:0] RESET_HITS    = 6'd4;
    localparam logic [15:0]      RESET_PATTERN = 16'h8888;

    typedef struct packed {
        logic [CNT_W-1:0] step_count;
        logic [CNT_W-1:0] hit_count;
        logic             clock_gate;
    } sample_t;

    typedef struct packed {
        logic                 pulse;
        logic [POS_OUT_W-1:0] position;
    } result_t;

    // Operands for the shared add / wrap unit.
    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [CNT_W-1:0] b;
        logic [CNT_W-1:0] m;
    } unit_req_t;

    typedef struct packed {
        logic             wrap;
        logic [ACC_W-1:0] res;
    } unit_rsp_t;

endpackage

`default_nettype wire

### design/egs_stream_if.sv
// Valid/ready stream channel with a typed payload.
`default_nettype none

interface egs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/egs_step_unit.sv
// Shared add-and-wrap unit: sum = a + b, subtract m once if sum >= m.
`default_nettype none

module egs_step_unit
    import egs_pkg::*;
(
    input  unit_req_t req,
    output unit_rsp_t rsp
);

    logic [ACC_W:0] sum;

    assign sum      = {1'b0, req.a} + (ACC_W + 1)'(req.b);
    assign rsp.wrap = sum >= (ACC_W + 1)'(req.m);
    assign rsp.res  = rsp.wrap ? ACC_W'(sum - (ACC_W + 1)'(req.m)) : ACC_W'(sum);

endmodule

`default_nettype wire

### design/euclidean_gate_sequencer.sv
// Euclidean gate sequencer top level: request intake, pattern rebuild, step advance.
// A rebuild runs when the step or hit count changes, a modulo walk of the position
//   runs on a rising gate edge, and the result is then registered for output.
// Throughput: one request at a time; intake stays closed through the rebuild and
//   modulo walk, which both use the single add/wrap unit.
// Reset (rst_n low, asynchronous): pattern 0x8888, 16 steps, 4 hits, position 0,
//   gate history low, no result pending.
`default_nettype none

module euclidean_gate_sequencer
    import egs_pkg::*;
#(
    parameter int MAX_STEPS = 32
)(
    input  wire              clk,
    input  wire              rst_n,
    egs_stream_if.sink       sample,
    egs_stream_if.source     result
);

    // Pattern register is wide enough for the reset pattern of 16 steps.
    localparam int PAT_W = (MAX_STEPS > 16) ? MAX_STEPS : 16;
    localparam int POS_W = $clog2(PAT_W);
    localparam logic [ACC_W-1:0] MAX_STEPS_V = ACC_W'(MAX_STEPS);
    localparam logic [PAT_W-1:0] RESET_PAT_V = PAT_W'(RESET_PATTERN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,    // one pattern step per cycle through the shared unit
        S_MOD,      // repeated subtract for the position wrap
        S_OUT
    } state_t;

    state_t           state_reg,        state_next;
    logic [PAT_W-1:0] pattern_reg,      pattern_next;
    logic [CNT_W-1:0] steps_reg,        steps_next;
    logic [CNT_W-1:0] hits_reg,         hits_next;
    logic [POS_W-1:0] pos_reg,          pos_next;
    logic             prev_gate_reg,    prev_gate_next;
    logic             edge_reg,         edge_next;
    logic [POS_W-1:0] idx_reg,          idx_next;
    logic [ACC_W-1:0] acc_reg,          acc_next;
    logic             out_valid_reg,    out_valid_next;
    result_t          out_reg,          out_next;

    logic [CNT_W-1:0] clamp_steps;
    logic [CNT_W-1:0] clamp_hits;
    logic             accept;
    unit_req_t        unit_req;
    unit_rsp_t        unit_rsp;
    logic [POS_OUT_W+POS_W-1:0] pos_ext;

    egs_step_unit u_step (
        .req (unit_req),
        .rsp (unit_rsp)
    );

    // Clamp incoming counts: zero steps means one, steps are capped at MAX_STEPS, hits never exceed steps.
    always_comb
    begin
        if (sample.payload.step_count == '0)
        begin
            clamp_steps = CNT_W'(1);
        end
        else if (ACC_W'(sample.payload.step_count) > MAX_STEPS_V)
        begin
            clamp_steps = MAX_STEPS_V[CNT_W-1:0];
        end
        else
        begin
            clamp_steps = sample.payload.step_count;
        end
        clamp_hits = (sample.payload.hit_count > clamp_steps) ? clamp_steps
                                                               : sample.payload.hit_count;
    end

    assign sample.ready  = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign accept        = sample.valid && sample.ready;
    assign result.valid  = out_valid_reg;
    assign result.payload = out_reg;
    assign pos_ext       = {{POS_OUT_W{1'b0}}, pos_reg};

    // Shared unit: accumulator + hits during rebuild, remainder - steps during wrap.
    always_comb
    begin
        unit_req.m = steps_reg;
        if (state_reg == S_BUILD)
        begin
            unit_req.a = acc_reg;
            unit_req.b = hits_reg;
        end
        else
        begin
            unit_req.a = acc_reg;
            unit_req.b = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pattern_next   = pattern_reg;
        steps_next     = steps_reg;
        hits_next      = hits_reg;
        pos_next       = pos_reg;
        prev_gate_next = prev_gate_reg;
        edge_next      = edge_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_next       = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    prev_gate_next = sample.payload.clock_gate;
                    edge_next      = sample.payload.clock_gate && !prev_gate_reg;
                    if (clamp_steps != steps_reg || clamp_hits != hits_reg)
                    begin
                        steps_next   = clamp_steps;
                        hits_next    = clamp_hits;
                        pattern_next = '0;
                        idx_next     = '0;
                        acc_next     = '0;
                        state_next   = S_BUILD;
                    end
                    else if (sample.payload.clock_gate && !prev_gate_reg)
                    begin
                        acc_next   = ACC_W'(pos_reg) + ACC_W'(1);
                        state_next = S_MOD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end

            S_BUILD:
            begin
                acc_next = unit_rsp.res;
                if (unit_rsp.wrap)
                begin
                    pattern_next[idx_reg] = 1'b1;
                end
                idx_next = idx_reg + POS_W'(1);
                if (ACC_W'(idx_reg) + ACC_W'(1) == ACC_W'(steps_reg))
                begin
                    if (edge_reg)
                    begin
                        acc_next   = ACC_W'(pos_reg) + ACC_W'(1);
                        state_next = S_MOD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end

            S_MOD:
            begin
                if (unit_rsp.wrap)
                begin
                    acc_next = unit_rsp.res;
                end
                else
                begin
                    pos_next   = acc_reg[POS_W-1:0];
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                out_valid_next    = 1'b1;
                out_next.pulse    = pattern_reg[pos_reg];
                out_next.position = pos_ext[POS_OUT_W-1:0];
                state_next        = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pattern_reg   <= RESET_PAT_V;
            steps_reg     <= RESET_STEPS;
            hits_reg      <= RESET_HITS;
            pos_reg       <= '0;
            prev_gate_reg <= 1'b0;
            edge_reg      <= 1'b0;
            idx_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pattern_reg   <= pattern_next;
            steps_reg     <= steps_next;
            hits_reg      <= hits_next;
            pos_reg       <= pos_next;
            prev_gate_reg <= prev_gate_next;
            edge_reg      <= edge_next;
            idx_reg       <= idx_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

`ifndef SYNTHESIS
    // One request in flight: intake closes right after an accept.
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("request accepted while previous one still in work");

    // Hits never exceed the stored step count.
    a_hits_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= steps_reg)
        else $error("stored hit count above stored step count");

    // Between requests, no pattern bit lies beyond the step count.
    a_pattern_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> (pattern_reg >> steps_reg) == '0)
        else $error("pattern bit set beyond step count");

    // The rebuild accumulator stays below the step count.
    a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BUILD |-> acc_reg < ACC_W'(steps_reg))
        else $error("rebuild accumulator out of range");

    // A result appears only from the output step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside output step");
`endif

endmodule

`default_nettype wire
